// ===== hw/rtl/lpfs_pkg.sv =====
package lpfs_pkg;

    // geometry of the page frame stack
    localparam int FRAMES    = 8;
    localparam int PAGE_BITS = 16;

    // fixed field widths
    localparam int CFG_W   = 4;
    localparam int DEPTH_W = 3;
    localparam int OCC_W   = 4;
    localparam int EPAGE_W = 16;
    localparam int IN_W    = 16;
    localparam int OUT_W   = 32;

    // derived widths
    localparam int CNT_W = $clog2(FRAMES + 1);
    localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    // configuration register indexes (word address bit)
    localparam logic REG_FRAMES_IN_USE = 1'b0;
    localparam logic [CFG_W-1:0] FRAMES_IN_USE_RESET = CFG_W'(8);

    typedef logic [PAGE_BITS-1:0] page_t;

    // control handed to each cell
    typedef struct packed {
        logic en;     // item accepted this cycle
        logic valid;  // cell lies below occupancy
        logic seen;   // a shallower cell already matched
    } lpfs_cell_ctl_t;

    // status returned by each cell
    typedef struct packed {
        logic seen;   // match here or in a shallower cell
        logic first;  // this cell holds the first match
    } lpfs_cell_stat_t;

endpackage

// ===== hw/rtl/lpfs_cell.sv =====
module lpfs_cell
(
    input  logic                     clk,
    input  lpfs_pkg::page_t          page,       // referenced page
    input  lpfs_pkg::page_t          prev_page,  // entry of the shallower neighbor
    input  lpfs_pkg::lpfs_cell_ctl_t ctl,
    output lpfs_pkg::page_t          data,
    output lpfs_pkg::lpfs_cell_stat_t stat
);

    lpfs_pkg::page_t data_reg;
    logic            match;

    // compare against the referenced page
    assign match      = ctl.valid && (data_reg == page);
    assign stat.seen  = ctl.seen | match;
    assign stat.first = match & ~ctl.seen;
    assign data       = data_reg;

    // shift down from the neighbor unless the hit lies shallower
    always_ff @(posedge clk)
    begin
        if (ctl.en && !ctl.seen)
        begin
            data_reg <= prev_page;
        end
    end

endmodule

// ===== hw/rtl/lru_page_frame_stack.sv =====
// LRU page frame stack: each input item carries one page reference and
// yields exactly one result item, registered on the output when the item
// is accepted. One item per cycle is taken as long as the result
// side keeps up; while a result waits, input stalls. The stack is a row of
// FRAMES cells, most recent first; every cell compares its page with the
// reference in parallel and a hit or miss shifts the shallower entries down
// one place in the same cycle. frames_in_use (address 0) limits occupancy;
// 0 acts as 1 and values above FRAMES act as FRAMES. Lowering it below the
// occupancy cuts the stack on the next miss. Stack contents need no clearing
// after reset; only entries below the occupancy are ever compared.
module lru_page_frame_stack
(
    input  logic        clk,
    input  logic        rst_n,
    // apb configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // reference stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] page_number
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [0] hit, [3:1] hit_depth, [4] evicted,
                                   // [20:5] evicted_page, [24:21] occupancy
);

    localparam int F  = lpfs_pkg::FRAMES;
    localparam int CW = lpfs_pkg::CNT_W;
    localparam int IW = lpfs_pkg::IDX_W;
    localparam int MW = lpfs_pkg::CMP_W;

    logic [lpfs_pkg::CFG_W-1:0] frames_reg;
    logic [CW-1:0]              count_reg;
    logic [CW-1:0]              count_next;
    logic                       out_valid_reg;
    logic [lpfs_pkg::OUT_W-1:0] out_data_reg;
    logic [lpfs_pkg::OUT_W-1:0] out_data_next;

    logic [CW-1:0]    limit;
    logic [MW-1:0]    cfg_ext;
    logic             accept;
    logic             hit;
    logic             full;
    logic [IW-1:0]    depth;
    logic [IW-1:0]    lim_idx;
    lpfs_pkg::page_t  page;
    lpfs_pkg::page_t  ev_page;

    lpfs_pkg::page_t          cell_data [F];
    lpfs_pkg::lpfs_cell_ctl_t cell_ctl  [F];
    lpfs_pkg::lpfs_cell_stat_t cell_stat [F];

    // configuration register
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_reg <= lpfs_pkg::FRAMES_IN_USE_RESET;
        end
        else if (psel && penable && pwrite && pready
                 && (paddr[2] == lpfs_pkg::REG_FRAMES_IN_USE))
        begin
            frames_reg <= pwdata[lpfs_pkg::CFG_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == lpfs_pkg::REG_FRAMES_IN_USE)
        begin
            prdata[lpfs_pkg::CFG_W-1:0] = frames_reg;
        end
    end

    // effective frame limit
    assign cfg_ext = MW'(frames_reg);

    always_comb
    begin
        if (cfg_ext == '0)
        begin
            limit = CW'(1);
        end
        else if (cfg_ext > MW'(F))
        begin
            limit = CW'(F);
        end
        else
        begin
            limit = CW'(cfg_ext);
        end
    end

    // handshake
    assign accept   = s_tvalid && s_tready;
    assign s_tready = !out_valid_reg || m_tready;
    assign page     = lpfs_pkg::PAGE_BITS'(s_tdata);

    // row of cells
    for (genvar i = 0; i < F; i++)
    begin : g_cell
        assign cell_ctl[i].en    = accept;
        assign cell_ctl[i].valid = (CW'(i) < count_reg);
        if (i == 0)
        begin : g_head
            assign cell_ctl[i].seen = 1'b0;
            lpfs_cell u_cell
            (
                .clk       (clk),
                .page      (page),
                .prev_page (page),
                .ctl       (cell_ctl[i]),
                .data      (cell_data[i]),
                .stat      (cell_stat[i])
            );
        end
        else
        begin : g_body
            assign cell_ctl[i].seen = cell_stat[i-1].seen;
            lpfs_cell u_cell
            (
                .clk       (clk),
                .page      (page),
                .prev_page (cell_data[i-1]),
                .ctl       (cell_ctl[i]),
                .data      (cell_data[i]),
                .stat      (cell_stat[i])
            );
        end
    end

    // hit position and eviction
    assign hit     = cell_stat[F-1].seen;
    assign full    = (count_reg >= limit);
    assign lim_idx = IW'(limit - CW'(1));
    assign ev_page = cell_data[lim_idx];

    always_comb
    begin
        depth = '0;
        for (int i = 0; i < F; i++)
        begin
            if (cell_stat[i].first)
            begin
                depth = depth | IW'(i);
            end
        end
    end

    // next occupancy
    always_comb
    begin
        if (hit)
        begin
            count_next = count_reg;
        end
        else if (full)
        begin
            count_next = limit;
        end
        else
        begin
            count_next = count_reg + CW'(1);
        end
    end

    // result packing
    always_comb
    begin
        out_data_next        = '0;
        out_data_next[0]     = hit;
        out_data_next[3:1]   = hit ? lpfs_pkg::DEPTH_W'(depth) : '0;
        out_data_next[4]     = !hit && full;
        out_data_next[20:5]  = (!hit && full) ? lpfs_pkg::EPAGE_W'(ev_page) : '0;
        out_data_next[24:21] = lpfs_pkg::OCC_W'(count_next);
    end

    // occupancy and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== tb/sv/lru_page_frame_stack_tb.sv =====
module lru_page_frame_stack_tb;

    import lpfs_pkg::*;

    localparam int HALF_PERIOD = 6;
    localparam int RESET_CYCLES = 12;
    localparam int CYCLE_LIMIT = 400000;
    localparam int BATCH_ITEMS = 100;
    localparam int BATCHES = 4;

    // expected outcome of one page reference
    typedef struct packed {
        logic               hit;
        logic [DEPTH_W-1:0] depth;
        logic               ev;
        page_t              ev_page;
        logic [OCC_W-1:0]   occ;
    } lru_outcome_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;   // [15:0] page_number
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;        // [0] hit, [3:1] hit_depth, [4] evicted,
                                 // [20:5] evicted_page, [24:21] occupancy

    // predictor state
    page_t            frame_stack [FRAMES];
    int               frames_held;
    logic [CFG_W-1:0] frames_cfg;

    lru_outcome_t pending_outcomes [$];
    lru_outcome_t want;
    int           err_count = 0;
    int unsigned  cycle_count = 0;
    int           src_idle_pct = 0;
    int           snk_stall_pct = 0;

    lru_page_frame_stack u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #HALF_PERIOD clk = ~clk;

    // run guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("** lru_page_frame_stack: FAILED **");
            $finish;
        end
    end

    // result side back pressure
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end

    // compare each result item with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_outcomes.size() == 0)
            begin
                $error("unexpected result item %h", m_tdata);
                err_count++;
            end
            else
            begin
                want = pending_outcomes.pop_front();
                if (m_tdata[0] !== want.hit)
                begin
                    $error("hit: expected %0d, got %0d", want.hit, m_tdata[0]);
                    err_count++;
                end
                if (m_tdata[3:1] !== want.depth)
                begin
                    $error("hit_depth: expected %0d, got %0d", want.depth, m_tdata[3:1]);
                    err_count++;
                end
                if (m_tdata[4] !== want.ev)
                begin
                    $error("evicted: expected %0d, got %0d", want.ev, m_tdata[4]);
                    err_count++;
                end
                if (m_tdata[20:5] !== want.ev_page)
                begin
                    $error("evicted_page: expected %h, got %h", want.ev_page, m_tdata[20:5]);
                    err_count++;
                end
                if (m_tdata[24:21] !== want.occ)
                begin
                    $error("occupancy: expected %0d, got %0d", want.occ, m_tdata[24:21]);
                    err_count++;
                end
            end
        end
    end

    // recency stack update for one reference, returns what the block reports
    function automatic lru_outcome_t lru_reference(page_t pg);
        int           limit;
        int           cnt;
        int           pos;
        bit           found;
        lru_outcome_t r;
        limit = (frames_cfg == 0) ? 1 : ((frames_cfg > FRAMES) ? FRAMES : int'(frames_cfg));
        cnt = (frames_held > FRAMES) ? FRAMES : frames_held;
        found = 1'b0;
        pos = 0;
        r = '0;
        for (int i = 0; i < cnt; i++)
        begin
            if (!found && frame_stack[i] == pg)
            begin
                found = 1'b1;
                pos = i;
            end
        end
        if (found)
        begin
            r.hit = 1'b1;
            r.depth = DEPTH_W'(pos);
            for (int i = pos; i > 0; i--)
                frame_stack[i] = frame_stack[i-1];
            frame_stack[0] = pg;
        end
        else
        begin
            // full at the current limit: drop the tail, cutting deeper entries too
            if (cnt >= limit)
            begin
                r.ev = 1'b1;
                r.ev_page = frame_stack[limit-1];
                cnt = limit - 1;
            end
            for (int i = cnt; i > 0; i--)
                frame_stack[i] = frame_stack[i-1];
            frame_stack[0] = pg;
            cnt++;
        end
        frames_held = cnt;
        r.occ = OCC_W'(cnt);
        return r;
    endfunction

    // offer one reference item and predict its result once accepted
    task automatic send_ref(input page_t pg);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            s_tdata <= 16'($urandom());
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata <= pg;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_outcomes.push_back(lru_reference(pg));
    endtask

    // hold input until every expected result has arrived
    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // one apb transfer: setup cycle then access cycle
    task automatic apb_xfer(input bit wr, input logic [31:0] wdata, output logic [31:0] rdata);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {REG_FRAMES_IN_USE, 2'b00};
        pwdata <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic check_frames_reg();
        logic [31:0] rd;
        apb_xfer(1'b0, 32'h0, rd);
        if (rd !== {{(32-CFG_W){1'b0}}, frames_cfg})
        begin
            $error("frames_in_use: expected %0d, got %0d", frames_cfg, rd);
            err_count++;
        end
    endtask

    // idle the block, write the frame limit with noise in the upper bits
    task automatic write_frames(input logic [CFG_W-1:0] val);
        logic [31:0] rd;
        wait_drained();
        apb_xfer(1'b1, {28'($urandom()), val}, rd);
        frames_cfg = val;
        check_frames_reg();
    endtask

    task automatic test_reset_value();
        check_frames_reg();
    endtask

    task automatic test_directed();
        src_idle_pct = 0;
        snk_stall_pct = 0;
        // extremes, hits at both ends of the stack, fill and evict
        send_ref(16'h0000);
        send_ref(16'hFFFF);
        send_ref(16'h0000);
        send_ref(16'h0000);
        send_ref(16'h1111);
        send_ref(16'h2222);
        send_ref(16'h3333);
        send_ref(16'h4444);
        send_ref(16'h5555);
        send_ref(16'h6666);
        send_ref(16'hFFFF);
        send_ref(16'hA5A5);
        send_ref(16'h5A5A);
        send_ref(frame_stack[FRAMES-1]);
        // limit lowered below occupancy: deep hit still found, miss cuts stack
        write_frames(4'd3);
        send_ref(frame_stack[6]);
        send_ref(16'h7777);
        send_ref(frame_stack[2]);
        send_ref(16'h8888);
        // limit zero behaves as one
        write_frames(4'd0);
        send_ref(16'h9999);
        send_ref(16'h9999);
        send_ref(16'hAAAA);
        // limit above the frame count behaves as the frame count
        write_frames(4'd15);
        send_ref(16'hBBBB);
        send_ref(16'hCCCC);
        send_ref(16'h9999);
        write_frames(4'd1);
        send_ref(16'hDDDD);
        send_ref(16'hDDDD);
    endtask

    task automatic test_random_phase(input int src, input int snk, input logic [CFG_W-1:0] cfg0);
        page_t pool [16];
        int    pool_n;
        page_t pg;
        src_idle_pct = src;
        snk_stall_pct = snk;
        for (int b = 0; b < BATCHES; b++)
        begin
            write_frames((b == 0) ? cfg0 : CFG_W'($urandom_range(0, 15)));
            pool_n = $urandom_range(2, 14);
            for (int k = 0; k < pool_n; k++)
                pool[k] = page_t'($urandom());
            pool[0] = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
            for (int n = 0; n < BATCH_ITEMS; n++)
            begin
                if ($urandom_range(0, 99) < 75)
                    pg = pool[$urandom_range(0, pool_n - 1)];
                else
                    pg = page_t'($urandom());
                send_ref(pg);
                // mid-batch pause until all results are back
                if (n == BATCH_ITEMS / 2)
                    wait_drained();
            end
        end
    endtask

    initial
    begin
        frames_cfg = FRAMES_IN_USE_RESET;
        frames_held = 0;
        for (int i = 0; i < FRAMES; i++)
            frame_stack[i] = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_value();
        test_directed();
        test_random_phase(0, 0, 4'd1);
        test_random_phase(56, 0, 4'd8);
        test_random_phase(0, 56, 4'd0);
        test_random_phase(32, 32, 4'd15);

        wait_drained();
        repeat (10) @(posedge clk);
        if (err_count == 0)
            $display("** lru_page_frame_stack: PASSED **");
        else
            $display("** lru_page_frame_stack: FAILED **");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/lpfs_pkg.sv
hw/rtl/lpfs_cell.sv
hw/rtl/lru_page_frame_stack.sv
tb/sv/lru_page_frame_stack_tb.sv
